// ===== design/bfcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit/fill command writer package
// Shared codes, register numbers, command and status types and helpers.
// ----------------------------------------------------------------------------
package bfcw_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_CARD_MODEL  = 2'd0;
  localparam logic [1:0] CFG_COLOR_SPACE = 2'd1;
  localparam logic [1:0] CFG_ROW_BYTES   = 2'd2;

  localparam logic [12:0] ROW_BYTES_RESET = 13'd640;

  // action codes
  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_BLIT   = 3'd1;
  localparam logic [2:0] ACT_FILL   = 3'd2;
  localparam logic [2:0] ACT_INVERT = 3'd3;
  localparam logic [2:0] ACT_RECT   = 3'd4;

  // colour space codes
  localparam logic [2:0] CS_8BPP  = 3'd0;
  localparam logic [2:0] CS_15BPP = 3'd1;
  localparam logic [2:0] CS_16BPP = 3'd2;
  localparam logic [2:0] CS_24BPP = 3'd3;

  // engine register numbers
  localparam logic [3:0] REG_CONTROL       = 4'd0;
  localparam logic [3:0] REG_STATUS        = 4'd1;
  localparam logic [3:0] REG_FGCOLOR       = 4'd2;
  localparam logic [3:0] REG_SRC_START     = 4'd3;
  localparam logic [3:0] REG_DST_START_OLD = 4'd4;
  localparam logic [3:0] REG_DST_START     = 4'd5;
  localparam logic [3:0] REG_EXTENT_OLD    = 4'd6;
  localparam logic [3:0] REG_EXTENT        = 4'd7;
  localparam logic [3:0] REG_PLANEMASK_OLD = 4'd8;
  localparam logic [3:0] REG_SRC_PITCH_OLD = 4'd9;
  localparam logic [3:0] REG_SRC_BIT_OLD   = 4'd10;
  localparam logic [3:0] REG_DST_PITCH_OLD = 4'd11;
  localparam logic [3:0] REG_DST_BIT_OLD   = 4'd12;
  localparam logic [3:0] REG_SRC_PITCH_NEW = 4'd13;

  // control word constants
  localparam logic [31:0] CTRL_BLIT_OLD   = 32'h000c0000;
  localparam logic [31:0] CTRL_BLIT_MID   = 32'h830c0000;
  localparam logic [31:0] CTRL_BLIT_NEW   = 32'h800c0000;
  localparam logic [31:0] CTRL_DIR_REV    = 32'h00000013;
  localparam logic [31:0] CTRL_FILL_OLD   = 32'h000c0008;
  localparam logic [31:0] CTRL_FILL_MID   = 32'h830c0008;
  localparam logic [31:0] CTRL_INVERT_OLD = 32'h00050000;
  localparam logic [31:0] CTRL_INVERT_MID = 32'h83050008;
  localparam logic [31:0] PLANEMASK_ALL   = 32'h0000ffff;

  // pitch table: pixels per row and matching code
  localparam int PITCH_ENTRIES = 6;
  localparam logic [10:0] PITCH_PIX [PITCH_ENTRIES] =
    '{11'd640, 11'd800, 11'd1024, 11'd1152, 11'd1280, 11'd1600};
  localparam logic [2:0] PITCH_CODE [PITCH_ENTRIES] =
    '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

  typedef enum logic [1:0] {FAM_OLD, FAM_MID, FAM_NEW} family_t;

  typedef enum logic [1:0] {S_IDLE, S_SRC, S_DST, S_EMIT} state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic mul_dst;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

  typedef struct packed {
    logic        write_valid;
    logic [3:0]  reg_id;
    logic [31:0] reg_data;
    logic        status;
    logic        last;
  } result_t;

  function automatic family_t family_of(input logic [3:0] cm);
    family_t f;
    if (cm == 4'd0) begin
      f = FAM_OLD;
    end else if (cm <= 4'd4) begin
      f = FAM_MID;
    end else begin
      f = FAM_NEW;
    end
    return f;
  endfunction

  // {match, code}: row_bytes / bpp equals a table entry
  function automatic logic [3:0] pitch_code(input logic [12:0] rb, input logic [1:0] bpp);
    logic [3:0]  r;
    logic [13:0] lo;
    r = 4'd0;
    for (int i = 0; i < PITCH_ENTRIES; i++) begin
      lo = 14'(PITCH_PIX[i]) * 14'(bpp);
      if ((14'(rb) >= lo) && (14'(rb) < lo + 14'(bpp))) begin
        r = {1'b1, PITCH_CODE[i]};
      end
    end
    return r;
  endfunction

  function automatic result_t mk_write(input logic [3:0] id, input logic [31:0] data,
                                       input logic lst);
    result_t r;
    r.write_valid = 1'b1;
    r.reg_id      = id;
    r.reg_data    = data;
    r.status      = 1'b0;
    r.last        = lst;
    return r;
  endfunction

  function automatic result_t mk_none(input logic st);
    result_t r;
    r.write_valid = 1'b0;
    r.reg_id      = REG_CONTROL;
    r.reg_data    = 32'd0;
    r.status      = st;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

// ===== design/bfcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit/fill command writer controller
// Sequences capture, address multiplies and result emission; owns handshakes.
// ----------------------------------------------------------------------------
module bfcw_ctrl
  import bfcw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SRC;
        end
      end
      S_SRC: begin
        cmd.prep   = 1'b1;
        state_next = S_DST;
      end
      S_DST: begin
        cmd.mul_dst = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          if (sts.last) begin
            // take the next transaction while the final result goes out
            in_ready = 1'b1;
            if (in_valid) begin
              cmd.capture = 1'b1;
              state_next  = S_SRC;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/bfcw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit/fill command writer datapath
// Configuration and engine state, operand capture, shared linear address
// multiplier, result selection and output register.
// ----------------------------------------------------------------------------
module bfcw_dp
  import bfcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic [2:0]  action,
  input  logic [15:0] src_x,
  input  logic [15:0] src_y,
  input  logic [15:0] dst_x,
  input  logic [15:0] dst_y,
  input  logic [15:0] width,
  input  logic [15:0] height,
  input  logic [15:0] x_end,
  input  logic [31:0] color,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic        write_valid,
  output logic [3:0]  reg_id,
  output logic [31:0] reg_data,
  output logic        status,
  output logic        last
);

  logic [3:0]  card_model;
  logic [2:0]  color_space;
  logic [12:0] row_bytes;

  logic [1:0]  depth;
  logic [2:0]  pcode;
  logic        b27;
  logic [1:0]  bpp;
  logic        init_err;

  logic [2:0]  act;
  logic [16:0] ax, ay, bx, by;
  logic [15:0] wid, hgt, rdx;
  logic [31:0] color_q;
  logic        rev;
  logic [31:0] src_lin, dst_lin;
  logic [2:0]  idx;

  family_t     fam;
  logic        fwd, rev_in;
  logic [16:0] mul_x, mul_y;
  logic [29:0] prod_y;
  logic [18:0] prod_x;
  logic [31:0] lin;
  logic        cs_ok, err24, code_bad, good;
  logic [1:0]  depth_n, bpp_n;
  logic [3:0]  pc;
  logic [31:0] ec, dirw, ctrl_word;
  result_t     res;

  assign fam = family_of(card_model);

  always_ff @(posedge clk) begin
    if (rst) begin
      card_model  <= 4'd0;
      color_space <= CS_8BPP;
      row_bytes   <= ROW_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CARD_MODEL:  card_model  <= cfg_data[3:0];
        CFG_COLOR_SPACE: color_space <= cfg_data[2:0];
        CFG_ROW_BYTES:   row_bytes   <= cfg_data;
        default: ;
      endcase
    end
  end

  // blit direction: copy from the lower right unless the destination leads
  assign fwd    = (dst_y < src_y) || ((dst_y == src_y) && (dst_x < src_x));
  assign rev_in = (action == ACT_BLIT) && !fwd;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act     <= action;
      rev     <= rev_in;
      ax      <= rev_in ? {1'b0, src_x} + {1'b0, width}  : {1'b0, src_x};
      ay      <= rev_in ? {1'b0, src_y} + {1'b0, height} : {1'b0, src_y};
      bx      <= rev_in ? {1'b0, dst_x} + {1'b0, width}  : {1'b0, dst_x};
      by      <= rev_in ? {1'b0, dst_y} + {1'b0, height} : {1'b0, dst_y};
      wid     <= width;
      hgt     <= height;
      rdx     <= x_end - src_x;
      color_q <= color;
    end
  end

  // shared linear address unit: y * row_bytes + x * bpp
  assign mul_x  = cmd.mul_dst ? bx : ax;
  assign mul_y  = cmd.mul_dst ? by : ay;
  assign prod_y = mul_y * row_bytes;
  assign prod_x = mul_x * bpp;
  assign lin    = 32'(prod_y) + 32'(prod_x);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      src_lin <= lin;
    end
    if (cmd.mul_dst) begin
      dst_lin <= lin;
    end
  end

  // init: depth, bytes per pixel and pitch code
  always_comb begin
    cs_ok   = 1'b1;
    depth_n = 2'd0;
    bpp_n   = 2'd0;
    case (color_space)
      CS_8BPP: begin
        depth_n = 2'd1;
        bpp_n   = 2'd1;
      end
      CS_15BPP, CS_16BPP: begin
        depth_n = 2'd2;
        bpp_n   = 2'd2;
      end
      CS_24BPP: begin
        depth_n = 2'd3;
        bpp_n   = 2'd3;
      end
      default: cs_ok = 1'b0;
    endcase
  end

  assign pc       = pitch_code(row_bytes, bpp_n);
  assign err24    = (color_space == CS_24BPP) && (fam != FAM_NEW);
  assign code_bad = (fam != FAM_OLD) && !pc[3];
  assign good     = cs_ok && !err24 && !code_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= 2'd0;
      pcode <= 3'd0;
      b27   <= 1'b0;
      bpp   <= 2'd0;
    end else if (cmd.prep && (act == ACT_INIT) && cs_ok) begin
      depth <= depth_n;
      bpp   <= bpp_n;
      pcode <= (good && (fam != FAM_OLD)) ? pc[2:0] : 3'd0;
      b27   <= good && ((card_model == 4'd1) || (card_model == 4'd2));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep && (act == ACT_INIT)) begin
      init_err <= !good;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (cmd.mul_dst) begin
      idx <= 3'd0;
    end else if (cmd.load_out) begin
      idx <= idx + 3'd1;
    end
  end

  assign ec   = {4'd0, b27, 14'd0, pcode, depth, 8'd0};
  assign dirw = rev ? CTRL_DIR_REV : 32'd0;

  always_comb begin
    case (act)
      ACT_BLIT: begin
        case (fam)
          FAM_OLD: ctrl_word = ec | CTRL_BLIT_OLD | dirw;
          FAM_MID: ctrl_word = ec | CTRL_BLIT_MID | dirw;
          default: ctrl_word = CTRL_BLIT_NEW | dirw;
        endcase
      end
      ACT_FILL: begin
        case (fam)
          FAM_OLD: ctrl_word = ec | CTRL_FILL_OLD;
          FAM_MID: ctrl_word = ec | CTRL_FILL_MID;
          default: ctrl_word = CTRL_FILL_MID;
        endcase
      end
      default: begin
        case (fam)
          FAM_OLD: ctrl_word = ec | CTRL_INVERT_OLD;
          FAM_MID: ctrl_word = ec | CTRL_INVERT_MID;
          default: ctrl_word = CTRL_INVERT_MID;
        endcase
      end
    endcase
  end

  always_comb begin
    res = mk_none(1'b0);
    case (act)
      ACT_INIT: begin
        if (init_err) begin
          res = mk_none(1'b1);
        end else if (fam == FAM_OLD) begin
          case (idx)
            3'd0:    res = mk_write(REG_PLANEMASK_OLD, PLANEMASK_ALL, 1'b0);
            3'd1:    res = mk_write(REG_SRC_PITCH_OLD, 32'(row_bytes), 1'b0);
            3'd2:    res = mk_write(REG_SRC_BIT_OLD, 32'd0, 1'b0);
            3'd3:    res = mk_write(REG_DST_PITCH_OLD, 32'(row_bytes), 1'b0);
            default: res = mk_write(REG_DST_BIT_OLD, 32'd0, 1'b1);
          endcase
        end else if (fam == FAM_NEW) begin
          case (idx)
            3'd0:    res = mk_write(REG_STATUS, {ec[15:0], 16'd0}, 1'b0);
            default: res = mk_write(REG_SRC_PITCH_NEW,
                                    {3'd0, row_bytes, 3'd0, row_bytes}, 1'b1);
          endcase
        end
      end
      ACT_BLIT: begin
        case (fam)
          FAM_OLD: begin
            case (idx)
              3'd0:    res = mk_write(REG_CONTROL, ctrl_word, 1'b0);
              3'd1:    res = mk_write(REG_EXTENT_OLD, {hgt, wid}, 1'b0);
              3'd2:    res = mk_write(REG_SRC_START, src_lin, 1'b0);
              default: res = mk_write(REG_DST_START_OLD, dst_lin, 1'b1);
            endcase
          end
          FAM_MID: begin
            case (idx)
              3'd0:    res = mk_write(REG_CONTROL, ctrl_word, 1'b0);
              3'd1:    res = mk_write(REG_SRC_START, {ay[15:0], ax[15:0]}, 1'b0);
              3'd2:    res = mk_write(REG_DST_START, {by[15:0], bx[15:0]}, 1'b0);
              default: res = mk_write(REG_EXTENT, {hgt + 16'd1, wid + 16'd1}, 1'b1);
            endcase
          end
          default: begin
            case (idx)
              3'd0:    res = mk_write(REG_CONTROL, ctrl_word, 1'b0);
              3'd1:    res = mk_write(REG_SRC_START, src_lin, 1'b0);
              3'd2:    res = mk_write(REG_DST_START, dst_lin, 1'b0);
              default: res = mk_write(REG_EXTENT, {hgt + 16'd1, wid + 16'd1}, 1'b1);
            endcase
          end
        endcase
      end
      ACT_FILL: begin
        if (idx == 3'd0) begin
          res = mk_write(REG_CONTROL, ctrl_word, 1'b0);
        end else if ((fam == FAM_OLD) && (bpp != 2'd1)) begin
          res = mk_write(REG_FGCOLOR, {16'd0, color_q[7:0], color_q[15:8]}, 1'b1);
        end else begin
          res = mk_write(REG_FGCOLOR, color_q, 1'b1);
        end
      end
      ACT_INVERT: begin
        if (idx == 3'd0) begin
          res = mk_write(REG_CONTROL, ctrl_word, 1'b0);
        end else begin
          res = mk_write(REG_FGCOLOR, 32'd0, 1'b1);
        end
      end
      ACT_RECT: begin
        if (rdx == 16'd0) begin
          res = mk_none(1'b0);
        end else if (fam == FAM_OLD) begin
          if (idx == 3'd0) begin
            res = mk_write(REG_EXTENT_OLD, {hgt - 16'd1, rdx - 16'd1}, 1'b0);
          end else begin
            res = mk_write(REG_DST_START_OLD, src_lin, 1'b1);
          end
        end else begin
          if (idx == 3'd0) begin
            res = mk_write(REG_DST_START, {ay[15:0], ax[15:0]}, 1'b0);
          end else begin
            res = mk_write(REG_EXTENT, {hgt, rdx}, 1'b1);
          end
        end
      end
      default: res = mk_none(1'b0);
    endcase
  end

  assign sts.last = res.last;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      write_valid <= res.write_valid;
      reg_id      <= res.reg_id;
      reg_data    <= res.reg_data;
      status      <= res.status;
      last        <= res.last;
    end
  end

endmodule

// ===== design/blit_fill_command_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit/fill command writer
// Turns init, blit, fill, invert and rectangle actions into ordered engine
// register writes.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction makes two passes through the shared linear address
// multiplier, source then destination, then its n results (1 to 5) are registered
// out one result a cycle while out_ready does not hold the output off.
// Reset: idle, output empty, card_model 0, color_space 0, row_bytes 640,
// engine control word and bytes per pixel zero.
module blit_fill_command_writer
  import bfcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] src_x,
  input  logic [15:0] src_y,
  input  logic [15:0] dst_x,
  input  logic [15:0] dst_y,
  input  logic [15:0] width,
  input  logic [15:0] height,
  input  logic [15:0] x_end,
  input  logic [31:0] color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_valid,
  output logic [3:0]  reg_id,
  output logic [31:0] reg_data,
  output logic        status,
  output logic        last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bfcw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .src_x       (src_x),
    .src_y       (src_y),
    .dst_x       (dst_x),
    .dst_y       (dst_y),
    .width       (width),
    .height      (height),
    .x_end       (x_end),
    .color       (color),
    .cmd         (cmd),
    .sts         (sts),
    .write_valid (write_valid),
    .reg_id      (reg_id),
    .reg_data    (reg_data),
    .status      (status),
    .last        (last)
  );

  a_accept_then_prep: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> cmd.prep)
    else $error("accepted transaction not followed by source address pass");

  a_prep_then_dst: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |=> cmd.mul_dst)
    else $error("source address pass not followed by destination pass");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && sts.last |-> in_ready)
    else $error("input held while final result loads");

  a_nonwrite_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> (reg_id == REG_CONTROL) && (reg_data == 32'd0))
    else $error("non-write result carries register or data");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit/fill command writer testbench
// Sends init, blit, fill, invert, rectangle and spare actions under a range of
// chip models, colour spaces and row pitches. A predictor in the bench works
// out the ordered register writes of every accepted action. Each output
// transaction is checked field by field against the oldest of these writes.
// Both sides idle at random, and the output is held off once for a long spell.
// ----------------------------------------------------------------------------
module tb_top;
  import bfcw_pkg::*;

  localparam int         LIMIT_NS        = 400_000;
  localparam int         MAX_PRINTED     = 40;
  localparam logic [1:0] CFG_SPARE       = 2'd3;
  localparam logic [2:0] CS_UNSUPPORTED  = 3'd4;
  localparam logic [2:0] CS_TOP          = 3'd7;
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam logic [3:0] MODEL_OLD       = 4'd0;
  localparam logic [3:0] MODEL_MID_FIRST = 4'd1;
  localparam logic [3:0] MODEL_WIDE_LAST = 4'd2;
  localparam logic [3:0] MODEL_MID_LAST  = 4'd4;
  localparam logic [3:0] MODEL_NEW_FIRST = 4'd5;
  localparam logic [3:0] MODEL_TOP       = 4'd8;
  localparam logic [3:0] MODEL_FIELD_MAX = 4'd15;
  localparam int unsigned PITCH_TABLE [6] = '{640, 800, 1024, 1152, 1280, 1600};

  typedef struct packed {
    logic [2:0]  act;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] xe;
    logic [31:0] col;
  } draw_cmd_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [15:0] src_x;
  logic [15:0] src_y;
  logic [15:0] dst_x;
  logic [15:0] dst_y;
  logic [15:0] width;
  logic [15:0] height;
  logic [15:0] x_end;
  logic [31:0] color;
  logic        out_valid;
  logic        out_ready;
  logic        write_valid;
  logic [3:0]  reg_id;
  logic [31:0] reg_data;
  logic        status;
  logic        last;

  blit_fill_command_writer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .src_x      (src_x),
    .src_y      (src_y),
    .dst_x      (dst_x),
    .dst_y      (dst_y),
    .width      (width),
    .height     (height),
    .x_end      (x_end),
    .color      (color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .write_valid(write_valid),
    .reg_id     (reg_id),
    .reg_data   (reg_data),
    .status     (status),
    .last       (last)
  );

  // engine settings and state as the bench sees them
  logic [3:0]  model_q;
  logic [2:0]  space_q;
  logic [12:0] pitch_bytes_q;
  logic [31:0] ctrl_word;
  logic [1:0]  pixel_bytes;

  result_t     expected_writes[$];
  result_t     action_writes[$];
  int unsigned mismatches;
  bit          sender_idles;
  bit          receiver_idles;
  int          hold_off_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [3:0] eff_model();
    return (model_q > MODEL_TOP) ? MODEL_TOP : model_q;
  endfunction

  function automatic logic [31:0] linear_addr(input logic [31:0] x, input logic [31:0] y);
    return y * 32'(pitch_bytes_q) + x * 32'(pixel_bytes);
  endfunction

  function automatic logic [31:0] packed_xy(input logic [31:0] x, input logic [31:0] y);
    return (y << 16) | (x & 32'h0000ffff);
  endfunction

  // {hit, code}
  function automatic logic [3:0] pitch_lookup(input logic [31:0] pix);
    logic [3:0] r;
    case (pix)
      32'd640:  r = {1'b1, 3'd2};
      32'd800:  r = {1'b1, 3'd3};
      32'd1024: r = {1'b1, 3'd4};
      32'd1152: r = {1'b1, 3'd5};
      32'd1280: r = {1'b1, 3'd6};
      32'd1600: r = {1'b1, 3'd7};
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

  task automatic add_write(input logic [3:0] id, input logic [31:0] data);
    result_t r;
    r.write_valid = 1'b1;
    r.reg_id      = id;
    r.reg_data    = data;
    r.status      = 1'b0;
    r.last        = 1'b0;
    action_writes.push_back(r);
  endtask

  task automatic add_none(input logic st);
    result_t r;
    r.write_valid = 1'b0;
    r.reg_id      = REG_CONTROL;
    r.reg_data    = 32'd0;
    r.status      = st;
    r.last        = 1'b0;
    action_writes.push_back(r);
  endtask

  task automatic predict_init();
    logic [3:0]  m;
    logic [31:0] pix;
    logic [3:0]  hit;
    logic        failed;
    m = eff_model();
    failed = 1'b0;
    case (space_q)
      CS_8BPP: begin
        ctrl_word   = 32'h0000_0100;
        pixel_bytes = 2'd1;
      end
      CS_15BPP, CS_16BPP: begin
        ctrl_word   = 32'h0000_0200;
        pixel_bytes = 2'd2;
      end
      CS_24BPP: begin
        ctrl_word   = 32'h0000_0300;
        pixel_bytes = 2'd3;
        failed      = (m < MODEL_NEW_FIRST);
      end
      default: failed = 1'b1;
    endcase
    if (!failed && m != MODEL_OLD) begin
      pix = 32'(pitch_bytes_q) / 32'(pixel_bytes);
      hit = pitch_lookup(pix);
      if (hit[3]) begin
        ctrl_word |= 32'(hit[2:0]) << 10;
      end else begin
        failed = 1'b1;
      end
    end
    if (failed) begin
      add_none(1'b1);
    end else begin
      if (m >= MODEL_MID_FIRST && m <= MODEL_WIDE_LAST) begin
        ctrl_word |= 32'd1 << 27;
      end
      if (m == MODEL_OLD) begin
        add_write(REG_PLANEMASK_OLD, PLANEMASK_ALL);
        add_write(REG_SRC_PITCH_OLD, 32'(pitch_bytes_q));
        add_write(REG_SRC_BIT_OLD, 32'd0);
        add_write(REG_DST_PITCH_OLD, 32'(pitch_bytes_q));
        add_write(REG_DST_BIT_OLD, 32'd0);
      end else if (m >= MODEL_NEW_FIRST) begin
        add_write(REG_STATUS, (ctrl_word & 32'h0000ffff) << 16);
        add_write(REG_SRC_PITCH_NEW, (32'(pitch_bytes_q) << 16) | 32'(pitch_bytes_q));
      end
    end
  endtask

  task automatic predict_blit(input draw_cmd_t c);
    logic [3:0]  m;
    logic [31:0] xs, ys, xd, yd, w, h, dir, ext;
    m   = eff_model();
    xs  = 32'(c.sx);
    ys  = 32'(c.sy);
    xd  = 32'(c.dx);
    yd  = 32'(c.dy);
    w   = 32'(c.w);
    h   = 32'(c.h);
    dir = 32'd0;
    ext = ((h + 32'd1) << 16) | ((w + 32'd1) & 32'h0000ffff);
    if (!((yd < ys) || (yd == ys && xd < xs))) begin
      dir = CTRL_DIR_REV;
      xs += w;
      ys += h;
      xd += w;
      yd += h;
    end
    if (m == MODEL_OLD) begin
      add_write(REG_CONTROL, ctrl_word | CTRL_BLIT_OLD | dir);
      add_write(REG_EXTENT_OLD, (h << 16) | (w & 32'h0000ffff));
      add_write(REG_SRC_START, linear_addr(xs, ys));
      add_write(REG_DST_START_OLD, linear_addr(xd, yd));
    end else if (m <= MODEL_MID_LAST) begin
      add_write(REG_CONTROL, ctrl_word | CTRL_BLIT_MID | dir);
      add_write(REG_SRC_START, packed_xy(xs, ys));
      add_write(REG_DST_START, packed_xy(xd, yd));
      add_write(REG_EXTENT, ext);
    end else begin
      add_write(REG_CONTROL, CTRL_BLIT_NEW | dir);
      add_write(REG_SRC_START, linear_addr(xs, ys));
      add_write(REG_DST_START, linear_addr(xd, yd));
      add_write(REG_EXTENT, ext);
    end
  endtask

  task automatic predict_fill(input logic [31:0] col);
    logic [3:0] m;
    m = eff_model();
    if (m == MODEL_OLD) begin
      add_write(REG_CONTROL, ctrl_word | CTRL_FILL_OLD);
      if (pixel_bytes == 2'd1) begin
        add_write(REG_FGCOLOR, col);
      end else begin
        add_write(REG_FGCOLOR, {16'd0, col[7:0], col[15:8]});
      end
    end else if (m <= MODEL_MID_LAST) begin
      add_write(REG_CONTROL, ctrl_word | CTRL_FILL_MID);
      add_write(REG_FGCOLOR, col);
    end else begin
      add_write(REG_CONTROL, CTRL_FILL_MID);
      add_write(REG_FGCOLOR, col);
    end
  endtask

  task automatic predict_invert();
    logic [3:0] m;
    m = eff_model();
    if (m == MODEL_OLD) begin
      add_write(REG_CONTROL, ctrl_word | CTRL_INVERT_OLD);
    end else if (m <= MODEL_MID_LAST) begin
      add_write(REG_CONTROL, ctrl_word | CTRL_INVERT_MID);
    end else begin
      add_write(REG_CONTROL, CTRL_INVERT_MID);
    end
    add_write(REG_FGCOLOR, 32'd0);
  endtask

  task automatic predict_rect(input draw_cmd_t c);
    logic [31:0] xs, ys, yl, xe;
    xs = 32'(c.sx);
    ys = 32'(c.sy);
    yl = 32'(c.h);
    xe = 32'(c.xe);
    if (xe != xs) begin
      if (eff_model() == MODEL_OLD) begin
        add_write(REG_EXTENT_OLD, ((yl - 32'd1) << 16) | ((xe - xs - 32'd1) & 32'h0000ffff));
        add_write(REG_DST_START_OLD, linear_addr(xs, ys));
      end else begin
        add_write(REG_DST_START, packed_xy(xs, ys));
        add_write(REG_EXTENT, (yl << 16) | ((xe - xs) & 32'h0000ffff));
      end
    end
  endtask

  task automatic predict_register_writes(input draw_cmd_t c);
    action_writes.delete();
    case (c.act)
      ACT_INIT:   predict_init();
      ACT_BLIT:   predict_blit(c);
      ACT_FILL:   predict_fill(c.col);
      ACT_INVERT: predict_invert();
      ACT_RECT:   predict_rect(c);
      default: ;
    endcase
    if (action_writes.size() == 0) begin
      add_none(1'b0);
    end
    action_writes[action_writes.size() - 1].last = 1'b1;
    foreach (action_writes[i]) begin
      expected_writes.push_back(action_writes[i]);
    end
  endtask

  // ----------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(name, got, want);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("transaction with nothing expected, reg_data", reg_data, 32'd0);
      end else begin
        want = expected_writes.pop_front();
        check_field("write_valid", 32'(write_valid), 32'(want.write_valid));
        check_field("reg_id", 32'(reg_id), 32'(want.reg_id));
        check_field("reg_data", reg_data, want.reg_data);
        check_field("status", 32'(status), 32'(want.status));
        check_field("last", 32'(last), 32'(want.last));
      end
    end
  end

  // ----------------------------------------------------------------- receiver
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------- sender
  task automatic send_action(input draw_cmd_t c);
    int gap;
    gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= c.act;
    src_x    <= c.sx;
    src_y    <= c.sy;
    dst_x    <= c.dx;
    dst_y    <= c.dy;
    width    <= c.w;
    height   <= c.h;
    x_end    <= c.xe;
    color    <= c.col;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_register_writes(c);
  endtask

  // drop valid only when a transaction is still in flight; otherwise it is already low
  task automatic drain_results();
    if (expected_writes.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_settings(input logic [3:0] cm, input logic [2:0] cs,
                                input logic [12:0] rb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CARD_MODEL;
    cfg_data  <= {9'($urandom), cm};
    @(posedge clk);
    cfg_index <= CFG_COLOR_SPACE;
    cfg_data  <= {10'($urandom), cs};
    @(posedge clk);
    cfg_index <= CFG_ROW_BYTES;
    cfg_data  <= rb;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 13'($urandom);
    @(posedge clk);
    cfg_we        <= 1'b0;
    model_q       = cm;
    space_q       = cs;
    pitch_bytes_q = rb;
  endtask

  function automatic draw_cmd_t make_cmd(input logic [2:0] act, input logic [15:0] sx,
                                         input logic [15:0] sy, input logic [15:0] dx,
                                         input logic [15:0] dy, input logic [15:0] w,
                                         input logic [15:0] h, input logic [15:0] xe,
                                         input logic [31:0] col);
    draw_cmd_t c;
    c.act = act;
    c.sx  = sx;
    c.sy  = sy;
    c.dx  = dx;
    c.dy  = dy;
    c.w   = w;
    c.h   = h;
    c.xe  = xe;
    c.col = col;
    return c;
  endfunction

  function automatic draw_cmd_t random_action();
    draw_cmd_t   c;
    int unsigned pick;
    c.sx  = 16'($urandom);
    c.sy  = 16'($urandom);
    c.dx  = 16'($urandom);
    c.dy  = 16'($urandom);
    c.w   = 16'($urandom);
    c.h   = 16'($urandom);
    c.xe  = 16'($urandom);
    c.col = $urandom;
    pick  = $urandom_range(0, 99);
    if (pick < 35) begin
      c.act = ACT_BLIT;
    end else if (pick < 65) begin
      c.act = ACT_RECT;
    end else if (pick < 80) begin
      c.act = ACT_FILL;
    end else if (pick < 90) begin
      c.act = ACT_INVERT;
    end else if (pick < 95) begin
      c.act = ACT_INIT;
    end else begin
      c.act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end
    // overlapping copies decide the direction
    if ($urandom_range(0, 2) == 0) begin
      c.dx = c.sx + 16'($urandom_range(0, 8)) - 16'd4;
      c.dy = c.sy + 16'($urandom_range(0, 2)) - 16'd1;
    end
    case ($urandom_range(0, 5))
      0:       c.xe = c.sx;
      1, 2:    c.xe = c.sx + 16'($urandom_range(1, 64));
      default: ;
    endcase
    if ($urandom_range(0, 1) == 0) begin
      c.w = 16'($urandom_range(0, 63));
      c.h = 16'($urandom_range(0, 63));
    end
    return c;
  endfunction

  task automatic random_settings();
    logic [3:0]  cm;
    logic [2:0]  cs;
    logic [12:0] rb;
    int unsigned bpp;
    cm = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(MODEL_TOP + 1, MODEL_FIELD_MAX))
                                     : 4'($urandom_range(MODEL_OLD, MODEL_TOP));
    cs = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(CS_UNSUPPORTED, CS_TOP))
                                     : 3'($urandom_range(CS_8BPP, CS_24BPP));
    bpp = (cs == CS_8BPP) ? 1 : (cs == CS_24BPP) ? 3 : 2;
    case ($urandom_range(0, 9))
      0:       rb = 13'($urandom);
      1:       rb = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'h1fff;
      default: rb = 13'(PITCH_TABLE[$urandom_range(0, 5)] * bpp + $urandom_range(0, bpp - 1));
    endcase
    write_settings(cm, cs, rb);
  endtask

  task automatic send_init();
    draw_cmd_t c;
    c     = random_action();
    c.act = ACT_INIT;
    send_action(c);
  endtask

  task automatic init_under(input logic [3:0] cm, input logic [2:0] cs, input logic [12:0] rb,
                            input draw_cmd_t follow);
    drain_results();
    write_settings(cm, cs, rb);
    send_init();
    send_action(follow);
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_before_init();
    send_action(make_cmd(ACT_BLIT, 16'd100, 16'd50, 16'd10, 16'd20, 16'd7, 16'd3, 16'd0, 32'd0));
    send_action(make_cmd(ACT_FILL, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                         32'hdead_beef));
    send_action(make_cmd(ACT_INVERT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0));
    send_action(make_cmd(ACT_RECT, 16'd5, 16'd6, 16'd0, 16'd0, 16'd0, 16'd4, 16'd25, 32'd0));
  endtask

  task automatic test_init_paths();
    draw_cmd_t blit_fwd, blit_rev, fill, invert;
    blit_fwd = make_cmd(ACT_BLIT, 16'd300, 16'd200, 16'd40, 16'd30, 16'd15, 16'd9, 16'd0, 32'd0);
    blit_rev = make_cmd(ACT_BLIT, 16'd10, 16'd10, 16'd12, 16'd10, 16'd31, 16'd7, 16'd0, 32'd0);
    fill     = make_cmd(ACT_FILL, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'h1234_5678);
    invert   = make_cmd(ACT_INVERT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    init_under(MODEL_OLD, CS_8BPP, 13'd640, fill);
    send_action(blit_rev);
    init_under(4'd3, CS_15BPP, 13'd1281, blit_fwd);
    init_under(MODEL_WIDE_LAST, CS_16BPP, 13'd2048, invert);
    init_under(MODEL_FIELD_MAX, CS_24BPP, 13'd4800, blit_rev);
    init_under(MODEL_MID_LAST, CS_24BPP, 13'd1920, fill);
    init_under(MODEL_MID_FIRST, CS_8BPP, 13'd700, invert);
    init_under(4'd6, CS_UNSUPPORTED, 13'd1024, invert);
  endtask

  task automatic test_spare_actions();
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
      send_action(make_cmd(3'(a), 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                           16'hffff, 32'hffff_ffff));
    end
  endtask

  task automatic test_field_extremes();
    drain_results();
    write_settings(MODEL_OLD, CS_16BPP, 13'h1fff);
    send_init();
    send_action(make_cmd(ACT_BLIT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0));
    send_action(make_cmd(ACT_BLIT, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                         16'hffff, 32'hffff_ffff));
    send_action(make_cmd(ACT_RECT, 16'd77, 16'd3, 16'd0, 16'd0, 16'd0, 16'd9, 16'd77, 32'd0));
    send_action(make_cmd(ACT_RECT, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0));
    send_action(make_cmd(ACT_FILL, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                         32'hffff_ffff));
  endtask

  task automatic test_random_sessions();
    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      random_settings();
      send_init();
      repeat ($urandom_range(15, 22)) send_action(random_action());
    end
  endtask

  // hold the output off while actions keep coming, so the input stalls
  task automatic test_back_pressure();
    drain_results();
    sender_idles    = 1'b0;
    hold_off_cycles = 120;
    repeat (12) send_action(random_action());
    drain_results();
    sender_idles = 1'b1;
  endtask

  task automatic test_steady_stream();
    drain_results();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    random_settings();
    send_init();
    repeat (20) send_action(random_action());
    drain_results();
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_CARD_MODEL;
    cfg_data  <= 13'd0;
    in_valid  <= 1'b0;
    action    <= ACT_INIT;
    src_x     <= 16'd0;
    src_y     <= 16'd0;
    dst_x     <= 16'd0;
    dst_y     <= 16'd0;
    width     <= 16'd0;
    height    <= 16'd0;
    x_end     <= 16'd0;
    color     <= 32'd0;
    model_q         = MODEL_OLD;
    space_q         = CS_8BPP;
    pitch_bytes_q   = ROW_BYTES_RESET;
    ctrl_word       = 32'd0;
    pixel_bytes     = 2'd0;
    mismatches      = 0;
    sender_idles    = 1'b1;
    receiver_idles  = 1'b1;
    hold_off_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_init();
    test_init_paths();
    test_spare_actions();
    test_field_extremes();
    test_random_sessions();
    test_back_pressure();
    test_steady_stream();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
